/* src/dstwr_pkg.sv */
package dstwr_pkg;

    // widths of the item fields
    localparam int TS_W      = 40;
    localparam int ADDR_W    = 64;
    localparam int SEQ_W     = 8;
    localparam int DIST_W    = 32;

    // stored timestamp width, at least 32 and at most TS_W
    localparam int TIME_BITS = 40;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_ADDRESS = 1'b0;
    localparam logic [ADDR_W-1:0] OWN_ADDR_RESET = 64'hBCCF_0000_0000_0001;

    // frame codes
    localparam logic CMD_TX_DONE  = 1'b0;
    localparam logic CMD_RX_FRAME = 1'b1;
    localparam logic [1:0] MSG_POLL   = 2'd0;
    localparam logic [1:0] MSG_ANSWER = 2'd1;
    localparam logic [1:0] MSG_FINAL  = 2'd2;
    localparam logic [1:0] MSG_REPORT = 2'd3;
    localparam logic [7:0] RELAY_ADDR_LSB = 8'hFE;

    // millimetres per tick in Q16
    localparam logic [31:0] MM_PER_TICK_Q16 = 32'd307479;

    // quotient bits produced by the divider once overflow is excluded
    localparam int DIV_STEPS = 31;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              cmd;
        logic [1:0]        msg_type;
        logic [SEQ_W-1:0]  seq;
        logic [ADDR_W-1:0] dest_addr;
        logic [TS_W-1:0]   event_time;
        logic [TS_W-1:0]   rep_poll_rx;
        logic [TS_W-1:0]   rep_answer_tx;
        logic [TS_W-1:0]   rep_final_rx;
        logic [SEQ_W-1:0]  expected_seq;
    } in_item_t;

    typedef struct packed {
        logic                     send_valid;
        logic [1:0]               send_type;
        logic [SEQ_W-1:0]         send_seq;
        logic [TS_W-1:0]          out_poll_rx;
        logic [TS_W-1:0]          out_answer_tx;
        logic [TS_W-1:0]          out_final_rx;
        logic                     dist_valid;
        logic signed [DIST_W-1:0] distance_mm;
        logic                     div_error;
    } out_item_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_DECODE,
        OP_DIFF,
        OP_ZERO,
        OP_MUL_A,
        OP_MUL_B,
        OP_MAG,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_SUM,
        OP_NUM,
        OP_PREP,
        OP_DIV,
        OP_DIST
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_report;
        logic s_zero;
        logic ovf;
        logic slot_free;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIFF,
        ST_ZCHK,
        ST_MUL_A,
        ST_MUL_B,
        ST_MAG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_NUM,
        ST_PREP,
        ST_DIV,
        ST_DIST,
        ST_FINISH
    } state_t;

endpackage

/* src/dstwr_ctrl.sv */
module dstwr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dstwr_pkg::dp_stat_t stat,
    output dstwr_pkg::dp_cmd_t  cmd
);

    dstwr_pkg::state_t                  state_reg;
    dstwr_pkg::state_t                  state_next;
    logic [dstwr_pkg::DIV_CNT_W-1:0]    div_cnt_reg;
    logic [dstwr_pkg::DIV_CNT_W-1:0]    div_cnt_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dstwr_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd.op       = dstwr_pkg::OP_NONE;
        cmd.load_out = 1'b0;
        in_stall     = 1'b1;
        case (state_reg)
            dstwr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = dstwr_pkg::OP_LATCH;
                    state_next = dstwr_pkg::ST_DECODE;
                end
            end
            dstwr_pkg::ST_DECODE:
            begin
                cmd.op     = dstwr_pkg::OP_DECODE;
                state_next = stat.is_report ? dstwr_pkg::ST_DIFF : dstwr_pkg::ST_FINISH;
            end
            dstwr_pkg::ST_DIFF:
            begin
                cmd.op     = dstwr_pkg::OP_DIFF;
                state_next = dstwr_pkg::ST_ZCHK;
            end
            dstwr_pkg::ST_ZCHK:
            begin
                cmd.op     = dstwr_pkg::OP_ZERO;
                state_next = stat.s_zero ? dstwr_pkg::ST_FINISH : dstwr_pkg::ST_MUL_A;
            end
            dstwr_pkg::ST_MUL_A:
            begin
                cmd.op     = dstwr_pkg::OP_MUL_A;
                state_next = dstwr_pkg::ST_MUL_B;
            end
            dstwr_pkg::ST_MUL_B:
            begin
                cmd.op     = dstwr_pkg::OP_MUL_B;
                state_next = dstwr_pkg::ST_MAG;
            end
            dstwr_pkg::ST_MAG:
            begin
                cmd.op     = dstwr_pkg::OP_MAG;
                state_next = dstwr_pkg::ST_MUL_LO;
            end
            dstwr_pkg::ST_MUL_LO:
            begin
                cmd.op     = dstwr_pkg::OP_MUL_LO;
                state_next = dstwr_pkg::ST_MUL_HI;
            end
            dstwr_pkg::ST_MUL_HI:
            begin
                cmd.op     = dstwr_pkg::OP_MUL_HI;
                state_next = dstwr_pkg::ST_SUM;
            end
            dstwr_pkg::ST_SUM:
            begin
                cmd.op     = dstwr_pkg::OP_SUM;
                state_next = dstwr_pkg::ST_NUM;
            end
            dstwr_pkg::ST_NUM:
            begin
                cmd.op     = dstwr_pkg::OP_NUM;
                state_next = dstwr_pkg::ST_PREP;
            end
            dstwr_pkg::ST_PREP:
            begin
                cmd.op       = dstwr_pkg::OP_PREP;
                div_cnt_next = '0;
                state_next   = dstwr_pkg::ST_DIV;
            end
            dstwr_pkg::ST_DIV:
            begin
                // saturated quotients skip the divide
                if (stat.ovf)
                begin
                    state_next = dstwr_pkg::ST_DIST;
                end
                else
                begin
                    cmd.op       = dstwr_pkg::OP_DIV;
                    div_cnt_next = div_cnt_reg + 1'b1;
                    if (div_cnt_reg == dstwr_pkg::DIV_CNT_W'(dstwr_pkg::DIV_STEPS - 1))
                    begin
                        state_next = dstwr_pkg::ST_DIST;
                    end
                end
            end
            dstwr_pkg::ST_DIST:
            begin
                cmd.op     = dstwr_pkg::OP_DIST;
                state_next = dstwr_pkg::ST_FINISH;
            end
            dstwr_pkg::ST_FINISH:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = dstwr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dstwr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/dstwr_dp.sv */
module dstwr_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dstwr_pkg::dp_cmd_t            cmd,
    output dstwr_pkg::dp_stat_t           stat,
    input  dstwr_pkg::in_item_t           in_data,
    input  logic [dstwr_pkg::ADDR_W-1:0]  own_address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output dstwr_pkg::out_item_t          out_data
);

    localparam int TB = dstwr_pkg::TIME_BITS;

    dstwr_pkg::in_item_t  item_reg;
    dstwr_pkg::out_item_t res_reg;
    dstwr_pkg::out_item_t res_next;
    dstwr_pkg::out_item_t out_data_reg;
    logic                 out_valid_reg;

    // ranging timestamps
    logic [TB-1:0] poll_sent_reg,    poll_sent_next;
    logic [TB-1:0] poll_arrive_reg,  poll_arrive_next;
    logic [TB-1:0] answer_sent_reg,  answer_sent_next;
    logic [TB-1:0] answer_arrive_reg, answer_arrive_next;
    logic [TB-1:0] final_sent_reg,   final_sent_next;
    logic [TB-1:0] final_arrive_reg, final_arrive_next;

    // distance arithmetic
    logic [31:0] ra_reg, pa_reg, rb_reg, pb_reg;
    logic [31:0] d_ra, d_pa, d_rb, d_pb;
    logic [33:0] s_reg;
    logic [63:0] a_reg, b_reg, mag_reg;
    logic        neg_reg;
    logic [50:0] plo_reg, phi_reg;
    logic [82:0] prod_reg;
    logic [84:0] num_reg;
    logic        ovf_reg;
    logic [50:0] rem_reg;
    logic [30:0] nlo_reg;
    logic [30:0] q_reg;
    logic [50:0] div_w;
    logic [51:0] rem_sh;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;

    // frame decode
    logic [TB-1:0] ev_time;
    logic          is_rx;
    logic          addr_hit;
    logic          seq_hit;

    assign ev_time  = item_reg.event_time[TB-1:0];
    assign is_rx    = (item_reg.cmd == dstwr_pkg::CMD_RX_FRAME);
    assign addr_hit = (item_reg.dest_addr[7:0] != dstwr_pkg::RELAY_ADDR_LSB)
                      && (item_reg.dest_addr == own_address);
    assign seq_hit  = (item_reg.seq == item_reg.expected_seq);

    assign div_w  = {s_reg, 17'b0};
    assign rem_sh = {rem_reg, nlo_reg[30]};

    assign stat.is_report = is_rx && addr_hit && seq_hit
                            && (item_reg.msg_type == dstwr_pkg::MSG_REPORT);
    assign stat.s_zero    = (s_reg == '0);
    assign stat.ovf       = ovf_reg;
    assign stat.slot_free = !out_valid_reg || !out_stall;

    // wrapped 32-bit interval differences
    assign d_ra = answer_arrive_reg[31:0] - poll_sent_reg[31:0];
    assign d_pa = answer_sent_reg[31:0] - poll_arrive_reg[31:0];
    assign d_rb = final_arrive_reg[31:0] - answer_sent_reg[31:0];
    assign d_pb = final_sent_reg[31:0] - answer_arrive_reg[31:0];

    // shared 32x32 multiplier
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (cmd.op)
            dstwr_pkg::OP_MUL_A:
            begin
                mul_x = ra_reg;
                mul_y = rb_reg;
            end
            dstwr_pkg::OP_MUL_B:
            begin
                mul_x = pa_reg;
                mul_y = pb_reg;
            end
            dstwr_pkg::OP_MUL_LO:
            begin
                mul_x = mag_reg[31:0];
                mul_y = dstwr_pkg::MM_PER_TICK_Q16;
            end
            dstwr_pkg::OP_MUL_HI:
            begin
                mul_x = mag_reg[63:32];
                mul_y = dstwr_pkg::MM_PER_TICK_Q16;
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    // timestamp updates and result forming
    always_comb
    begin
        poll_sent_next     = poll_sent_reg;
        poll_arrive_next   = poll_arrive_reg;
        answer_sent_next   = answer_sent_reg;
        answer_arrive_next = answer_arrive_reg;
        final_sent_next    = final_sent_reg;
        final_arrive_next  = final_arrive_reg;
        res_next           = res_reg;
        case (cmd.op)
            dstwr_pkg::OP_DECODE:
            begin
                res_next = '0;
                if (!is_rx)
                begin
                    // departure time stored under the sent type
                    case (item_reg.msg_type)
                        dstwr_pkg::MSG_POLL:   poll_sent_next   = ev_time;
                        dstwr_pkg::MSG_ANSWER: answer_sent_next = ev_time;
                        dstwr_pkg::MSG_FINAL:  final_sent_next  = ev_time;
                        default:               final_sent_next  = final_sent_reg;
                    endcase
                end
                else if (addr_hit)
                begin
                    case (item_reg.msg_type)
                        dstwr_pkg::MSG_POLL:
                        begin
                            poll_arrive_next    = ev_time;
                            res_next.send_valid = 1'b1;
                            res_next.send_type  = dstwr_pkg::MSG_ANSWER;
                            res_next.send_seq   = item_reg.seq;
                        end
                        dstwr_pkg::MSG_FINAL:
                        begin
                            final_arrive_next      = ev_time;
                            res_next.send_valid    = 1'b1;
                            res_next.send_type     = dstwr_pkg::MSG_REPORT;
                            res_next.send_seq      = item_reg.seq;
                            res_next.out_poll_rx   = dstwr_pkg::TS_W'(poll_arrive_reg);
                            res_next.out_answer_tx = dstwr_pkg::TS_W'(answer_sent_reg);
                            res_next.out_final_rx  = dstwr_pkg::TS_W'(ev_time);
                        end
                        dstwr_pkg::MSG_ANSWER:
                        begin
                            if (seq_hit)
                            begin
                                answer_arrive_next  = ev_time;
                                res_next.send_valid = 1'b1;
                                res_next.send_type  = dstwr_pkg::MSG_FINAL;
                                res_next.send_seq   = item_reg.seq;
                            end
                        end
                        default:
                        begin
                            // report: take the peer's timestamps
                            if (seq_hit)
                            begin
                                poll_arrive_next  = item_reg.rep_poll_rx[TB-1:0];
                                answer_sent_next  = item_reg.rep_answer_tx[TB-1:0];
                                final_arrive_next = item_reg.rep_final_rx[TB-1:0];
                            end
                        end
                    endcase
                end
            end
            dstwr_pkg::OP_ZERO:
            begin
                if (s_reg == '0)
                begin
                    res_next.div_error = 1'b1;
                end
            end
            dstwr_pkg::OP_DIST:
            begin
                res_next.dist_valid = 1'b1;
                if (!neg_reg)
                begin
                    res_next.distance_mm = ovf_reg ? dstwr_pkg::DIST_MAX
                                                   : $signed({1'b0, q_reg});
                end
                else
                begin
                    res_next.distance_mm = ovf_reg ? dstwr_pkg::DIST_MIN
                                                   : $signed(32'd0 - {1'b0, q_reg});
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // timestamp state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_sent_reg     <= '0;
            poll_arrive_reg   <= '0;
            answer_sent_reg   <= '0;
            answer_arrive_reg <= '0;
            final_sent_reg    <= '0;
            final_arrive_reg  <= '0;
        end
        else
        begin
            poll_sent_reg     <= poll_sent_next;
            poll_arrive_reg   <= poll_arrive_next;
            answer_sent_reg   <= answer_sent_next;
            answer_arrive_reg <= answer_arrive_next;
            final_sent_reg    <= final_sent_next;
            final_arrive_reg  <= final_arrive_next;
        end
    end

    // item, result and arithmetic registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        case (cmd.op)
            dstwr_pkg::OP_LATCH:
            begin
                item_reg <= in_data;
            end
            dstwr_pkg::OP_DIFF:
            begin
                ra_reg <= d_ra;
                pa_reg <= d_pa;
                rb_reg <= d_rb;
                pb_reg <= d_pb;
                s_reg  <= 34'(d_ra) + 34'(d_rb) + 34'(d_pa) + 34'(d_pb);
            end
            dstwr_pkg::OP_MUL_A:
            begin
                a_reg <= mul_p;
            end
            dstwr_pkg::OP_MUL_B:
            begin
                b_reg <= mul_p;
            end
            dstwr_pkg::OP_MAG:
            begin
                if (a_reg >= b_reg)
                begin
                    mag_reg <= a_reg - b_reg;
                    neg_reg <= 1'b0;
                end
                else
                begin
                    mag_reg <= b_reg - a_reg;
                    neg_reg <= 1'b1;
                end
            end
            dstwr_pkg::OP_MUL_LO:
            begin
                plo_reg <= mul_p[50:0];
            end
            dstwr_pkg::OP_MUL_HI:
            begin
                phi_reg <= mul_p[50:0];
            end
            dstwr_pkg::OP_SUM:
            begin
                prod_reg <= {phi_reg, 32'b0} + 83'(plo_reg);
            end
            dstwr_pkg::OP_NUM:
            begin
                // twice the product plus half the divisor rounds the quotient
                num_reg <= 85'({prod_reg, 1'b0}) + 85'({s_reg, 16'b0});
            end
            dstwr_pkg::OP_PREP:
            begin
                ovf_reg <= (num_reg[84:31] >= 54'(div_w));
                rem_reg <= num_reg[81:31];
                nlo_reg <= num_reg[30:0];
                q_reg   <= '0;
            end
            dstwr_pkg::OP_DIV:
            begin
                // one restoring step per cycle
                if (rem_sh >= 52'(div_w))
                begin
                    rem_reg <= 51'(rem_sh - 52'(div_w));
                    q_reg   <= {q_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[50:0];
                    q_reg   <= {q_reg[29:0], 1'b0};
                end
                nlo_reg <= {nlo_reg[29:0], 1'b0};
            end
            default:
            begin
                item_reg <= item_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* src/ds_twr_ranging_engine_core.sv */
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   in_data (frame or transmit-done event)
// out       output     out_valid/out_stall out_data (reply, distance, error flags)
// cfg       input      psel/penable        own_address at byte address 0
//
// an event or a poll, answer or final frame goes from decode straight to finish
// a report with matching sequence also runs the distance steps, with the 31-step divider
// and the single shared 32x32 multiplier used four times; a saturated distance
// skips the divider and a zero divisor finishes after the zero check;
// one item at a time; a finished result waits in the output register while
// the next item is taken; timestamps clear to zero on rst_n
module ds_twr_ranging_engine_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  dstwr_pkg::in_item_t               in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output dstwr_pkg::out_item_t              out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dstwr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [dstwr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [dstwr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready
);

    logic [dstwr_pkg::ADDR_W-1:0] own_addr_reg;
    dstwr_pkg::dp_cmd_t           cmd;
    dstwr_pkg::dp_stat_t          stat;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= dstwr_pkg::OWN_ADDR_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr == dstwr_pkg::CFG_OWN_ADDRESS))
        begin
            own_addr_reg <= pwdata;
        end
    end

    assign prdata = (paddr == dstwr_pkg::CFG_OWN_ADDRESS) ? own_addr_reg : '0;

    // sequencer
    dstwr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // timestamps and distance arithmetic
    dstwr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_data     (in_data),
        .own_address (own_addr_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    // busy right after an input transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while previous item in flight");

    // a distance and a divide error never come together
    a_dist_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.dist_valid && out_data.div_error))
        else $error("distance and divide error both set");

    // a distance result carries no reply frame
    a_dist_no_send: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.dist_valid) |-> !out_data.send_valid)
        else $error("distance result with reply frame");

    // replies are never polls
    a_send_type: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.send_valid) |-> (out_data.send_type != dstwr_pkg::MSG_POLL))
        else $error("reply of type poll");

endmodule

/* sim/tb_ds_twr_ranging_engine_core.sv */
module tb_ds_twr_ranging_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dstwr_pkg::*;

    localparam logic [TS_W-1:0] TS_MASK = TS_W'((64'd1 << TIME_BITS) - 64'd1);
    localparam out_item_t NO_REPLY = '0;
    localparam int PHASES = 6;

    typedef struct {
        bit        fixed;
        out_item_t val;
    } fixed_reply_t;

    typedef struct {
        in_item_t  item;
        bit        fixed;
        out_item_t val;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor copy of the node state
    logic [ADDR_W-1:0] node_addr = OWN_ADDR_RESET;
    logic [TS_W-1:0]   poll_sent_ts = '0;
    logic [TS_W-1:0]   poll_arrive_ts = '0;
    logic [TS_W-1:0]   answer_sent_ts = '0;
    logic [TS_W-1:0]   answer_arrive_ts = '0;
    logic [TS_W-1:0]   final_sent_ts = '0;
    logic [TS_W-1:0]   final_arrive_ts = '0;

    out_item_t    reply_q[$];
    fixed_reply_t tag_q[$];
    dir_row_t     dir_rows[$];

    int  errors = 0;
    int  sent_count = 0;
    int  result_count = 0;
    int  useful_count = 0;
    int  dist_count = 0;
    int  zero_div_count = 0;
    int  settings_count = 0;
    bit  quiet = 1'b0;
    logic [ADDR_W-1:0] cur_addr = OWN_ADDR_RESET;

    ds_twr_ranging_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic logic [TS_W-1:0] rand40();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TS_W-1:0];
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // distance from the six stored timestamps, rounded half away from zero
    function automatic void range_distance(output logic ok,
                                           output logic [DIST_W-1:0] dist_val);
        logic [31:0]  ra, pa, rb, pb;
        logic [33:0]  sum;
        logic [63:0]  prod_a, prod_b, mag;
        logic         neg;
        logic [127:0] num, den, quo;
        ra = 32'(answer_arrive_ts - poll_sent_ts);
        pa = 32'(answer_sent_ts - poll_arrive_ts);
        rb = 32'(final_arrive_ts - answer_sent_ts);
        pb = 32'(final_sent_ts - answer_arrive_ts);
        sum = 34'(ra) + 34'(rb) + 34'(pa) + 34'(pb);
        prod_a = 64'(ra) * 64'(rb);
        prod_b = 64'(pa) * 64'(pb);
        ok = 1'b0;
        dist_val = '0;
        if (sum != '0)
        begin
            ok = 1'b1;
            neg = prod_a < prod_b;
            mag = neg ? prod_b - prod_a : prod_a - prod_b;
            den = 128'(sum) << 16;
            num = ((128'(mag) * 128'(MM_PER_TICK_Q16)) << 1) + den;
            quo = num / (den << 1);
            if (!neg)
                dist_val = (quo > 128'h7FFF_FFFF) ? DIST_MAX : quo[31:0];
            else
            begin
                if (quo > 128'h8000_0000)
                    quo = 128'h8000_0000;
                dist_val = 32'(128'd0 - quo);
            end
        end
    endfunction

    // next reply of the engine for one transfer, updates the state copy
    function automatic out_item_t ranging_predict(input in_item_t it);
        out_item_t r;
        logic      ok;
        logic [DIST_W-1:0] d;
        r = NO_REPLY;
        if (it.cmd == CMD_TX_DONE)
        begin
            case (it.msg_type)
                MSG_POLL:   poll_sent_ts = it.event_time & TS_MASK;
                MSG_ANSWER: answer_sent_ts = it.event_time & TS_MASK;
                MSG_FINAL:  final_sent_ts = it.event_time & TS_MASK;
                default:    ;
            endcase
            return r;
        end
        if (it.dest_addr[7:0] == RELAY_ADDR_LSB || it.dest_addr != node_addr)
            return r;
        case (it.msg_type)
            MSG_POLL:
            begin
                poll_arrive_ts = it.event_time & TS_MASK;
                r.send_valid = 1'b1;
                r.send_type = MSG_ANSWER;
                r.send_seq = it.seq;
            end
            MSG_FINAL:
            begin
                final_arrive_ts = it.event_time & TS_MASK;
                r.send_valid = 1'b1;
                r.send_type = MSG_REPORT;
                r.send_seq = it.seq;
                r.out_poll_rx = poll_arrive_ts;
                r.out_answer_tx = answer_sent_ts;
                r.out_final_rx = final_arrive_ts;
            end
            MSG_ANSWER:
            begin
                if (it.seq == it.expected_seq)
                begin
                    answer_arrive_ts = it.event_time & TS_MASK;
                    r.send_valid = 1'b1;
                    r.send_type = MSG_FINAL;
                    r.send_seq = it.seq;
                end
            end
            default:
            begin
                if (it.seq == it.expected_seq)
                begin
                    poll_arrive_ts = it.rep_poll_rx & TS_MASK;
                    answer_sent_ts = it.rep_answer_tx & TS_MASK;
                    final_arrive_ts = it.rep_final_rx & TS_MASK;
                    range_distance(ok, d);
                    r.dist_valid = ok;
                    r.distance_mm = d;
                    r.div_error = !ok;
                end
            end
        endcase
        return r;
    endfunction

    // scoreboard: predict on input transfer, compare on output transfer
    always @(posedge clk)
    begin : track
        out_item_t    want;
        out_item_t    got;
        fixed_reply_t tag;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == CFG_OWN_ADDRESS)
                node_addr = pwdata;
            if (in_valid && !in_stall)
            begin
                want = ranging_predict(in_data);
                tag = tag_q.pop_front();
                if (tag.fixed)
                    want = tag.val;
                if (want != NO_REPLY ||
                    (in_data.cmd == CMD_TX_DONE && in_data.msg_type != MSG_REPORT))
                    useful_count++;
                if (want.dist_valid)
                    dist_count++;
                if (want.div_error)
                    zero_div_count++;
                reply_q.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                result_count++;
                got = out_data;
                if (reply_q.size() == 0)
                    report_mismatch("result transfer with nothing pending");
                else
                begin
                    want = reply_q.pop_front();
                    check_field("send_valid", 64'(got.send_valid), 64'(want.send_valid));
                    check_field("send_type", 64'(got.send_type), 64'(want.send_type));
                    check_field("send_seq", 64'(got.send_seq), 64'(want.send_seq));
                    check_field("out_poll_rx", 64'(got.out_poll_rx), 64'(want.out_poll_rx));
                    check_field("out_answer_tx", 64'(got.out_answer_tx),
                                64'(want.out_answer_tx));
                    check_field("out_final_rx", 64'(got.out_final_rx),
                                64'(want.out_final_rx));
                    check_field("dist_valid", 64'(got.dist_valid), 64'(want.dist_valid));
                    check_field("distance_mm", 64'(got.distance_mm), 64'(want.distance_mm));
                    check_field("div_error", 64'(got.div_error), 64'(want.div_error));
                end
            end
        end
    end

    // receiver side stall per result
    initial
    begin : sink
        int n;
        @(posedge clk iff rst_n);
        forever
        begin
            n = draw_wait();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // one input transfer after a random gap
    task automatic send_frame(input in_item_t it, input bit fixed, input out_item_t val);
        int gap;
        fixed_reply_t tag;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tag.fixed = fixed;
        tag.val = val;
        tag_q.push_back(tag);
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (result_count != sent_count || reply_q.size() != 0)
            @(posedge clk);
    endtask

    // register write followed by a read back
    task automatic cfg_write(input logic [ADDR_W-1:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_OWN_ADDRESS;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== v)
            report_mismatch($sformatf("own_address read %0h want %0h", prdata, v));
        psel <= 1'b0;
        penable <= 1'b0;
        cur_addr = v;
        settings_count++;
    endtask

    function automatic in_item_t mk_in(input logic cmd, input logic [1:0] typ,
                                       input logic [7:0] seq, input logic [63:0] dest,
                                       input logic [TS_W-1:0] t,
                                       input logic [TS_W-1:0] prx,
                                       input logic [TS_W-1:0] atx,
                                       input logic [TS_W-1:0] frx,
                                       input logic [7:0] eseq);
        in_item_t it;
        it.cmd = cmd;
        it.msg_type = typ;
        it.seq = seq;
        it.dest_addr = dest;
        it.event_time = t;
        it.rep_poll_rx = prx;
        it.rep_answer_tx = atx;
        it.rep_final_rx = frx;
        it.expected_seq = eseq;
        return it;
    endfunction

    function automatic out_item_t mk_reply(input logic [1:0] typ, input logic [7:0] seq,
                                           input logic [TS_W-1:0] prx,
                                           input logic [TS_W-1:0] atx,
                                           input logic [TS_W-1:0] frx);
        out_item_t r;
        r = NO_REPLY;
        r.send_valid = 1'b1;
        r.send_type = typ;
        r.send_seq = seq;
        r.out_poll_rx = prx;
        r.out_answer_tx = atx;
        r.out_final_rx = frx;
        return r;
    endfunction

    function automatic out_item_t mk_dist(input logic dv, input logic [DIST_W-1:0] d,
                                          input logic de);
        out_item_t r;
        r = NO_REPLY;
        r.dist_valid = dv;
        r.distance_mm = d;
        r.div_error = de;
        return r;
    endfunction

    task automatic add_row(input in_item_t it, input bit fixed, input out_item_t val);
        dir_row_t row;
        row.item = it;
        row.fixed = fixed;
        row.val = val;
        dir_rows.push_back(row);
    endtask

    function automatic logic [63:0] pick_dest();
        int k;
        k = $urandom_range(0, 19);
        if (k < 12)
            return cur_addr;
        if (k < 15)
            return {cur_addr[63:8], RELAY_ADDR_LSB};
        return rand64();
    endfunction

    // filler transfer with random content
    function automatic in_item_t rand_frame();
        in_item_t it;
        it = mk_in(1'($urandom), 2'($urandom), 8'($urandom), pick_dest(), rand40(),
                   rand40(), rand40(), rand40(), 8'($urandom));
        if ($urandom_range(0, 1))
            it.expected_seq = it.seq;
        return it;
    endfunction

    function automatic logic [7:0] maybe_break(input logic [7:0] s);
        return ($urandom_range(0, 9) == 0) ? s + 8'(1 + $urandom_range(0, 254)) : s;
    endfunction

    // this node starts the exchange and computes the distance
    task automatic run_initiator();
        logic [63:0] t1, t2, tof, da, db;
        logic [7:0]  s;
        s = 8'($urandom);
        t1 = rand64();
        t2 = rand64();
        tof = 64'($urandom_range(0, 3000));
        db = 64'($urandom_range(50, 1 << $urandom_range(8, 28)));
        da = 64'($urandom_range(50, 1 << $urandom_range(8, 28)));
        if ($urandom_range(0, 7) == 0)
            tof = tof + 64'($urandom_range(0, 100)) - 64'd50;
        send_frame(mk_in(CMD_TX_DONE, MSG_POLL, 8'($urandom), rand64(), t1[TS_W-1:0],
                         rand40(), rand40(), rand40(), 8'($urandom)), 1'b0, NO_REPLY);
        send_frame(mk_in(CMD_RX_FRAME, MSG_ANSWER, maybe_break(s), cur_addr,
                         TS_W'(t1 + 2 * tof + db), rand40(), rand40(), rand40(), s),
                   1'b0, NO_REPLY);
        send_frame(mk_in(CMD_TX_DONE, MSG_FINAL, 8'($urandom), rand64(),
                         TS_W'(t1 + 2 * tof + db + da), rand40(), rand40(), rand40(),
                         8'($urandom)), 1'b0, NO_REPLY);
        if ($urandom_range(0, 5) == 0)
            send_frame(rand_frame(), 1'b0, NO_REPLY);
        send_frame(mk_in(CMD_RX_FRAME, MSG_REPORT, maybe_break(s), cur_addr, rand40(),
                         TS_W'(t2), TS_W'(t2 + db), TS_W'(t2 + db + da + 2 * tof), s),
                   1'b0, NO_REPLY);
    endtask

    // this node answers the exchange and reports its timestamps
    task automatic run_responder();
        logic [63:0] t2, tof, da, db;
        logic [7:0]  s;
        s = 8'($urandom);
        t2 = rand64();
        tof = 64'($urandom_range(0, 3000));
        db = 64'($urandom_range(50, 1 << $urandom_range(8, 28)));
        da = 64'($urandom_range(50, 1 << $urandom_range(8, 28)));
        send_frame(mk_in(CMD_RX_FRAME, MSG_POLL, s, cur_addr, TS_W'(t2), rand40(), rand40(),
                         rand40(), 8'($urandom)), 1'b0, NO_REPLY);
        send_frame(mk_in(CMD_TX_DONE, MSG_ANSWER, s, rand64(), TS_W'(t2 + db), rand40(),
                         rand40(), rand40(), 8'($urandom)), 1'b0, NO_REPLY);
        send_frame(mk_in(CMD_RX_FRAME, MSG_FINAL, s, cur_addr, TS_W'(t2 + db + da + 2 * tof),
                         rand40(), rand40(), rand40(), 8'($urandom)), 1'b0, NO_REPLY);
        send_frame(mk_in(CMD_TX_DONE, MSG_REPORT, s, rand64(), rand40(), rand40(), rand40(),
                         rand40(), 8'($urandom)), 1'b0, NO_REPLY);
    endtask

    initial
    begin : stimulus
        logic [63:0] phase_addr[PHASES];
        int          phase_quota[PHASES];
        int          k;
        logic [63:0] own;
        own = OWN_ADDR_RESET;

        // reset
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: replies after reset, ignored frames, ranging extremes
        add_row(mk_in(CMD_RX_FRAME, MSG_POLL, 8'h00, own, '0, '0, '0, '0, 8'h00),
                1'b1, mk_reply(MSG_ANSWER, 8'h00, '0, '0, '0));
        add_row(mk_in(CMD_RX_FRAME, MSG_POLL, 8'hFF, own, '1, '1, '1, '1, 8'hFF),
                1'b1, mk_reply(MSG_ANSWER, 8'hFF, '0, '0, '0));
        add_row(mk_in(CMD_RX_FRAME, MSG_FINAL, 8'h5A, own, 40'h12_3456_789A, '0, '0, '0,
                      8'h00), 1'b1, mk_reply(MSG_REPORT, 8'h5A, '1, '0, 40'h12_3456_789A));
        add_row(mk_in(CMD_TX_DONE, MSG_REPORT, 8'h11, '1, 40'h77_7777_7777, '1, '1, '1,
                      8'h11), 1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_POLL, 8'h21, {own[63:8], RELAY_ADDR_LSB}, '0, '0, '0,
                      '0, 8'h21), 1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_POLL, 8'h22, 64'h0, '0, '0, '0, '0, 8'h22),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_FINAL, 8'h23, '1, '0, '0, '0, '0, 8'h23),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_ANSWER, 8'h03, own, 40'd77, '0, '0, '0, 8'h04),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_REPORT, 8'h03, own, '0, '1, '1, '1, 8'h04),
                1'b1, NO_REPLY);
        // ordinary exchange, about a quarter metre
        add_row(mk_in(CMD_TX_DONE, MSG_POLL, 8'h07, '0, 40'd1000, '0, '0, '0, 8'h07),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_ANSWER, 8'h07, own, 40'd6100, '0, '0, '0, 8'h07),
                1'b1, mk_reply(MSG_FINAL, 8'h07, '0, '0, '0));
        add_row(mk_in(CMD_TX_DONE, MSG_ANSWER, 8'h07, '0, 40'd12345, '0, '0, '0, 8'h07),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_TX_DONE, MSG_FINAL, 8'h07, '0, 40'd10100, '0, '0, '0, 8'h07),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_REPORT, 8'h07, own, '0, 40'd500000, 40'd505000,
                      40'd509100, 8'h07), 1'b0, NO_REPLY);
        // all round trips zero: no distance
        add_row(mk_in(CMD_TX_DONE, MSG_POLL, 8'h09, '0, 40'h55_0000_0000, '0, '0, '0, 8'h09),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_ANSWER, 8'h09, own, 40'h55_0000_0000, '0, '0, '0,
                      8'h09), 1'b1, mk_reply(MSG_FINAL, 8'h09, '0, '0, '0));
        add_row(mk_in(CMD_TX_DONE, MSG_FINAL, 8'h09, '0, 40'h55_0000_0000, '0, '0, '0, 8'h09),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_REPORT, 8'h09, own, '0, 40'hAA_AAAA_AAAA,
                      40'hAA_AAAA_AAAA, 40'hAA_AAAA_AAAA, 8'h09), 1'b1,
                mk_dist(1'b0, '0, 1'b1));
        // largest positive product: clamps high
        add_row(mk_in(CMD_TX_DONE, MSG_POLL, 8'h10, '0, '0, '0, '0, '0, 8'h10),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_ANSWER, 8'h10, own, 40'h00_FFFF_FFFF, '0, '0, '0,
                      8'h10), 1'b1, mk_reply(MSG_FINAL, 8'h10, '0, '0, '0));
        add_row(mk_in(CMD_TX_DONE, MSG_FINAL, 8'h10, '0, 40'h00_FFFF_FFFF, '0, '0, '0, 8'h10),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_REPORT, 8'h10, own, '0, 40'h10_0000_0000,
                      40'h10_0000_0000, 40'h0F_FFFF_FFFF, 8'h10), 1'b1,
                mk_dist(1'b1, DIST_MAX, 1'b0));
        // largest negative product: clamps low
        add_row(mk_in(CMD_TX_DONE, MSG_POLL, 8'hFF, '0, '1, '0, '0, '0, 8'hFF),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_ANSWER, 8'hFF, own, '1, '0, '0, '0, 8'hFF),
                1'b1, mk_reply(MSG_FINAL, 8'hFF, '0, '0, '0));
        add_row(mk_in(CMD_TX_DONE, MSG_FINAL, 8'hFF, '0, 40'h00_FFFF_FFFE, '0, '0, '0, 8'hFF),
                1'b1, NO_REPLY);
        add_row(mk_in(CMD_RX_FRAME, MSG_REPORT, 8'hFF, own, '0, '0, 40'h00_FFFF_FFFF,
                      40'h00_FFFF_FFFF, 8'hFF), 1'b1, mk_dist(1'b1, DIST_MIN, 1'b0));

        foreach (dir_rows[i])
            send_frame(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].val);
        drain();

        // random phases, one address setting each
        phase_addr = '{64'h0, '1, rand64(), rand64(), OWN_ADDR_RESET,
                       64'({rand64() >> 8, RELAY_ADDR_LSB})};
        phase_quota = '{150, 150, 140, 125, 125, 30};
        for (int p = 0; p < PHASES; p++)
        begin
            cfg_write(phase_addr[p]);
            useful_count = 0;
            while (useful_count < phase_quota[p])
            begin
                if ($urandom_range(0, 15) == 0)
                    quiet = ~quiet;
                k = $urandom_range(0, 19);
                if (k < 8)
                    run_initiator();
                else if (k < 13)
                    run_responder();
                else
                    repeat ($urandom_range(1, 3)) send_frame(rand_frame(), 1'b0, NO_REPLY);
            end
            drain();
        end

        // end of run
        repeat (60) @(posedge clk);
        if (reply_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", reply_q.size()));
        $display("run: %0d transfers in, %0d results out, %0d address settings",
                 sent_count, result_count, settings_count);
        $display("run: %0d distances, %0d zero-divisor reports", dist_count, zero_div_count);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
